// File: rtl/core/i2a_pkg.sv
// Shared constants, types and helper functions for the integer to ASCII formatter.
`default_nettype none

package i2a_pkg;

    localparam int MAX_DIGITS = 22;
    localparam int MAX_WIDTH  = 64;
    localparam int MAX_PREC   = MAX_WIDTH - 3;
    localparam int DEC_DIGITS = 20;
    localparam int VALUE_W    = 64;

    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int POS_W  = $clog2(MAX_WIDTH + 1);
    localparam int STEP_W = $clog2(VALUE_W);
    localparam int FW_W   = 7;
    localparam int PREC_W = 6;

    localparam logic [1:0] BASE_OCT  = 2'd0;
    localparam logic [1:0] BASE_DEC  = 2'd1;
    localparam logic [1:0] BASE_HEX  = 2'd2;
    localparam logic [1:0] BASE_RSVD = 2'd3;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_MINUS = 2'd1;
    localparam logic [1:0] SIGN_PLUS  = 2'd2;
    localparam logic [1:0] SIGN_SPACE = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_A_UP  = 8'h41;

    typedef logic [3:0] digit_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [1:0]         base_select;
        logic               uppercase;
        logic               alt_form;
        logic               left_adjust;
        logic               zero_pad;
        logic [FW_W-1:0]    field_width;
        logic               precision_given;
        logic [PREC_W-1:0]  precision;
        logic [1:0]         sign_code;
    } fmt_t;

    typedef struct packed {
        logic load;
        logic radix_step;
        logic dd_step;
        logic scan_mode;
        logic scan_step;
        logic plan_a;
        logic plan_b;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic load_dec;
        logic value_zero;
        logic dd_last;
        logic scan_done;
        logic out_free;
        logic last_pos;
    } stat_t;

    function automatic logic [7:0] digit_char(input digit_t d, input logic upper);
        logic [7:0] base_ch;
        if (d < 4'd10)
        begin
            return CH_ZERO + {4'b0, d};
        end
        base_ch = upper ? CH_A_UP : CH_A_LO;
        return base_ch + {4'b0, d} - 8'd10;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/i2a_in_if.sv
// Request channel: one integer with its format fields.
`default_nettype none

interface i2a_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [1:0]  base_select;
    logic        uppercase;
    logic        alt_form;
    logic        left_adjust;
    logic        zero_pad;
    logic [6:0]  field_width;
    logic        precision_given;
    logic [5:0]  precision;
    logic [1:0]  sign_code;

    modport source (
        output valid, value, base_select, uppercase, alt_form, left_adjust, zero_pad,
               field_width, precision_given, precision, sign_code,
        input  ready
    );

    modport sink (
        input  valid, value, base_select, uppercase, alt_form, left_adjust, zero_pad,
               field_width, precision_given, precision, sign_code,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/i2a_out_if.sv
// Character channel: one output character with an end-of-text flag.
`default_nettype none

interface i2a_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (
        output valid, out_char, last_char,
        input  ready
    );

    modport sink (
        input  valid, out_char, last_char,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/integer_to_ascii_formatter.sv
// After load, decimal digits come from a 64-step double dabble over the digit store; the zero
// scan then drops leading zeros one per cycle. Octal and hex digits are shifted out of the
// value until it is zero. Layout steps plan_a and plan_b follow; characters then leave one
// per cycle while the receiver is ready (max(width, text length), at most 64 per request).
// A new request is taken once the last character sits in the output register.
// Reset (rst_n, async active low) clears the controller, digit count, character position and output valid.
`default_nettype none

module integer_to_ascii_formatter (
    input  wire logic   clk,
    input  wire logic   rst_n,
    i2a_in_if.sink      req,
    i2a_out_if.source   txt
);

    i2a_pkg::fmt_t  fmt;
    i2a_pkg::cmd_t  cmd;
    i2a_pkg::stat_t stat;
    logic           req_ready;
    logic           txt_valid;
    logic [7:0]     txt_char;
    logic           txt_last;

    assign fmt.value           = req.value;
    assign fmt.base_select     = req.base_select;
    assign fmt.uppercase       = req.uppercase;
    assign fmt.alt_form        = req.alt_form;
    assign fmt.left_adjust     = req.left_adjust;
    assign fmt.zero_pad        = req.zero_pad;
    assign fmt.field_width     = req.field_width;
    assign fmt.precision_given = req.precision_given;
    assign fmt.precision       = req.precision;
    assign fmt.sign_code       = req.sign_code;

    i2a_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    i2a_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .fmt       (fmt),
        .cmd       (cmd),
        .stat      (stat),
        .txt_ready (txt.ready),
        .txt_valid (txt_valid),
        .txt_char  (txt_char),
        .txt_last  (txt_last)
    );

    assign req.ready     = req_ready;
    assign txt.valid     = txt_valid;
    assign txt.out_char  = txt_char;
    assign txt.last_char = txt_last;

endmodule

`default_nettype wire

// File: rtl/core/i2a_datapath.sv
// Datapath: digit extraction, digit store, field layout and character output register.
`default_nettype none

module i2a_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire i2a_pkg::fmt_t fmt,
    input  wire i2a_pkg::cmd_t cmd,
    output i2a_pkg::stat_t     stat,
    input  wire logic          txt_ready,
    output logic               txt_valid,
    output logic [7:0]         txt_char,
    output logic               txt_last
);

    localparam int CNT_W  = i2a_pkg::CNT_W;
    localparam int POS_W  = i2a_pkg::POS_W;
    localparam int IDX_W  = i2a_pkg::IDX_W;
    localparam int VW     = i2a_pkg::VALUE_W;

    // control state
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              valid_reg, valid_next;

    // payload
    i2a_pkg::digit_t   digits_reg [i2a_pkg::MAX_DIGITS];
    i2a_pkg::digit_t   digits_next [i2a_pkg::MAX_DIGITS];
    i2a_pkg::digit_t   adj [i2a_pkg::DEC_DIGITS];
    logic [VW-1:0]     value_reg, value_next;
    logic [i2a_pkg::STEP_W-1:0] step_reg, step_next;

    logic [1:0]        base_reg;
    logic              upper_reg, alt_reg, left_reg, zpad_reg, pgiven_reg;
    logic [i2a_pkg::FW_W-1:0]   width_reg;
    logic [i2a_pkg::PREC_W-1:0] prec_reg;
    logic [1:0]        scode_reg;

    logic [i2a_pkg::PREC_W-1:0] zfill_reg;
    logic [1:0]        pref_reg;
    logic [POS_W-1:0]  core_reg, pad_reg;
    logic              zmode_reg;
    logic [POS_W-1:0]  b0_reg, b1_reg, b2_reg, b4_reg, b5_reg, total_reg;
    logic              blank_reg;

    logic [7:0]        char_reg;
    logic              last_reg;

    // planning terms
    logic [i2a_pkg::PREC_W-1:0] mind;
    logic [i2a_pkg::PREC_W-1:0] zfill_calc;
    logic [1:0]        pref_calc;
    logic              sign_len;
    logic [POS_W-1:0]  core_calc, pad_calc;
    logic [POS_W-1:0]  b0_calc, b1_calc, b2_calc, b3_calc, b4_calc, b5_calc, total_calc;

    // emission
    logic [POS_W-1:0]  emit_off;
    logic [IDX_W-1:0]  rd_idx;
    i2a_pkg::digit_t   rd_digit;
    logic [7:0]        emit_char;
    logic              is_dec_in;

    assign is_dec_in = (fmt.base_select == i2a_pkg::BASE_DEC)
                    || (fmt.base_select == i2a_pkg::BASE_RSVD);

    assign emit_off = b5_reg - {{(POS_W-1){1'b0}}, 1'b1} - pos_reg;
    assign rd_idx   = cmd.scan_mode ? IDX_W'(count_reg - {{(CNT_W-1){1'b0}}, 1'b1})
                                    : emit_off[IDX_W-1:0];
    assign rd_digit = digits_reg[rd_idx];

    assign stat.load_dec   = is_dec_in;
    assign stat.value_zero = (value_reg == '0);
    assign stat.dd_last    = &step_reg;
    assign stat.scan_done  = (count_reg == '0) || (rd_digit != 4'd0);
    assign stat.out_free   = !valid_reg || txt_ready;
    assign stat.last_pos   = (pos_reg == total_reg - {{(POS_W-1){1'b0}}, 1'b1});

    // layout, first half
    always_comb
    begin
        mind       = pgiven_reg ? prec_reg : {{(i2a_pkg::PREC_W-1){1'b0}}, 1'b1};
        zfill_calc = (mind > {1'b0, count_reg}) ? mind - {1'b0, count_reg} : '0;
        sign_len   = (scode_reg != i2a_pkg::SIGN_NONE);
        if (alt_reg && (base_reg == i2a_pkg::BASE_OCT) && (zfill_calc == '0))
        begin
            pref_calc = 2'd1;
        end
        else if (alt_reg && (base_reg == i2a_pkg::BASE_HEX) && (count_reg != '0))
        begin
            pref_calc = 2'd2;
        end
        else
        begin
            pref_calc = 2'd0;
        end
        core_calc = {{(POS_W-1){1'b0}}, sign_len} + {{(POS_W-2){1'b0}}, pref_calc}
                  + {1'b0, zfill_calc} + {{(POS_W-CNT_W){1'b0}}, count_reg};
        pad_calc  = (width_reg > core_calc) ? width_reg - core_calc : '0;
    end

    // layout, second half: segment boundaries
    always_comb
    begin
        b0_calc    = (!left_reg && !zmode_reg) ? pad_reg : '0;
        b1_calc    = b0_calc + {{(POS_W-1){1'b0}}, sign_len};
        b2_calc    = b1_calc + {{(POS_W-2){1'b0}}, pref_reg};
        b3_calc    = b2_calc + (zmode_reg ? pad_reg : '0);
        b4_calc    = b3_calc + {1'b0, zfill_reg};
        b5_calc    = b4_calc + {{(POS_W-CNT_W){1'b0}}, count_reg};
        total_calc = (width_reg > core_reg) ? width_reg : core_reg;
        if (total_calc == '0)
        begin
            total_calc = {{(POS_W-1){1'b0}}, 1'b1};
        end
    end

    always_comb
    begin
        if (blank_reg)
        begin
            emit_char = i2a_pkg::CH_ZERO;
        end
        else if (pos_reg < b0_reg)
        begin
            emit_char = i2a_pkg::CH_SPACE;
        end
        else if (pos_reg < b1_reg)
        begin
            case (scode_reg)
                i2a_pkg::SIGN_MINUS: emit_char = i2a_pkg::CH_MINUS;
                i2a_pkg::SIGN_PLUS:  emit_char = i2a_pkg::CH_PLUS;
                default:             emit_char = i2a_pkg::CH_SPACE;
            endcase
        end
        else if (pos_reg < b2_reg)
        begin
            if (pos_reg == b1_reg)
            begin
                emit_char = i2a_pkg::CH_ZERO;
            end
            else
            begin
                emit_char = upper_reg ? i2a_pkg::CH_X_UP : i2a_pkg::CH_X_LO;
            end
        end
        else if (pos_reg < b4_reg)
        begin
            emit_char = i2a_pkg::CH_ZERO;
        end
        else if (pos_reg < b5_reg)
        begin
            emit_char = i2a_pkg::digit_char(rd_digit, upper_reg);
        end
        else
        begin
            emit_char = i2a_pkg::CH_SPACE;
        end
    end

    // digit store: radix digits by shifting, decimal by double dabble in place
    always_comb
    begin
        digits_next = digits_reg;
        value_next  = value_reg;
        step_next   = step_reg;
        for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++)
        begin
            adj[i] = (digits_reg[i] >= 4'd5) ? digits_reg[i] + 4'd3 : digits_reg[i];
        end
        if (cmd.load)
        begin
            for (int i = 0; i < i2a_pkg::MAX_DIGITS; i++)
            begin
                digits_next[i] = '0;
            end
            value_next = fmt.value;
            step_next  = '0;
        end
        else if (cmd.radix_step)
        begin
            if (base_reg == i2a_pkg::BASE_OCT)
            begin
                digits_next[count_reg[IDX_W-1:0]] = {1'b0, value_reg[2:0]};
                value_next = value_reg >> 3;
            end
            else
            begin
                digits_next[count_reg[IDX_W-1:0]] = value_reg[3:0];
                value_next = value_reg >> 4;
            end
        end
        else if (cmd.dd_step)
        begin
            digits_next[0] = {adj[0][2:0], value_reg[VW-1]};
            for (int i = 1; i < i2a_pkg::DEC_DIGITS; i++)
            begin
                digits_next[i] = {adj[i][2:0], adj[i-1][3]};
            end
            value_next = value_reg << 1;
            step_next  = step_reg + 1'b1;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.load)
        begin
            count_next = is_dec_in ? CNT_W'(i2a_pkg::DEC_DIGITS) : '0;
        end
        else if (cmd.radix_step)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.scan_step)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        valid_next = valid_reg;
        if (cmd.plan_b)
        begin
            pos_next = '0;
        end
        else if (cmd.emit)
        begin
            pos_next = stat.last_pos ? '0 : pos_reg + 1'b1;
        end
        if (cmd.emit)
        begin
            valid_next = 1'b1;
        end
        else if (txt_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pos_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            pos_reg   <= pos_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        value_reg  <= value_next;
        step_reg   <= step_next;
        if (cmd.load)
        begin
            base_reg   <= fmt.base_select;
            upper_reg  <= fmt.uppercase;
            alt_reg    <= fmt.alt_form;
            left_reg   <= fmt.left_adjust;
            zpad_reg   <= fmt.zero_pad;
            pgiven_reg <= fmt.precision_given;
            scode_reg  <= fmt.sign_code;
            width_reg  <= (fmt.field_width > i2a_pkg::FW_W'(i2a_pkg::MAX_WIDTH))
                        ? i2a_pkg::FW_W'(i2a_pkg::MAX_WIDTH) : fmt.field_width;
            prec_reg   <= (fmt.precision > i2a_pkg::PREC_W'(i2a_pkg::MAX_PREC))
                        ? i2a_pkg::PREC_W'(i2a_pkg::MAX_PREC) : fmt.precision;
        end
        if (cmd.plan_a)
        begin
            zfill_reg <= zfill_calc;
            pref_reg  <= pref_calc;
            core_reg  <= core_calc;
            pad_reg   <= pad_calc;
            zmode_reg <= zpad_reg && !left_reg && !pgiven_reg;
        end
        if (cmd.plan_b)
        begin
            b0_reg    <= b0_calc;
            b1_reg    <= b1_calc;
            b2_reg    <= b2_calc;
            b4_reg    <= b4_calc;
            b5_reg    <= b5_calc;
            total_reg <= total_calc;
            blank_reg <= (core_reg == '0) && (width_reg == '0);
        end
        if (cmd.emit)
        begin
            char_reg <= emit_char;
            last_reg <= stat.last_pos;
        end
    end

    assign txt_valid = valid_reg;
    assign txt_char  = char_reg;
    assign txt_last  = last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(i2a_pkg::MAX_DIGITS))
        else $error("digit count beyond store depth");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (pos_reg < total_reg))
        else $error("character position past end of text");

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> (count_reg != '0))
        else $error("leading zero scan below first digit");

    a_pos_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.last_pos) |=> (pos_reg == '0))
        else $error("position not cleared after last character");

endmodule

`default_nettype wire

// File: rtl/core/i2a_ctrl.sv
// Controller: sequences load, digit extraction, zero scan, layout and character emission.
`default_nettype none

module i2a_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire i2a_pkg::stat_t stat,
    output i2a_pkg::cmd_t       cmd
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_RADIX  = 3'd1;
    localparam logic [2:0] ST_DEC    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_PLAN_A = 3'd4;
    localparam logic [2:0] ST_PLAN_B = 3'd5;
    localparam logic [2:0] ST_EMIT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        req_ready     = 1'b0;
        cmd.scan_mode = (state_reg == ST_SCAN);
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.load_dec ? ST_DEC : ST_RADIX;
                end
            end
            ST_RADIX:
            begin
                if (stat.value_zero)
                begin
                    state_next = ST_PLAN_A;
                end
                else
                begin
                    cmd.radix_step = 1'b1;
                end
            end
            ST_DEC:
            begin
                cmd.dd_step = 1'b1;
                if (stat.dd_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = ST_PLAN_A;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_PLAN_A:
            begin
                cmd.plan_a = 1'b1;
                state_next = ST_PLAN_B;
            end
            ST_PLAN_B:
            begin
                cmd.plan_b = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (stat.last_pos)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && stat.last_pos) |=> (state_reg == ST_IDLE))
        else $error("controller did not finish after last character");

    a_dec_to_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.dd_step && stat.dd_last) |=> (state_reg == ST_SCAN))
        else $error("decimal conversion did not hand over to zero scan");

    a_plan_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.plan_a |=> cmd.plan_b)
        else $error("layout steps out of order");

endmodule

`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for integer_to_ascii_formatter: predicted printf text vs. streamed chars.
`timescale 1ns / 1ps

module tb;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 150;
    localparam int RANDOM_ITEMS = 250;

    typedef struct {
        i2a_pkg::fmt_t fmt;
        bit            drain_first;
    } pending_t;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } text_char_t;

    typedef enum int {RX_FREE, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_style_t;

    logic clk;
    logic rst_n;

    i2a_in_if  req ();
    i2a_out_if txt ();

    integer_to_ascii_formatter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .txt   (txt)
    );

    pending_t   pending_reqs[$];
    text_char_t expected_chars[$];
    text_char_t want;
    bit         in_fire;
    int         mismatch_count;
    int         cycle_count;
    int         burst_left;
    int         gap_left;
    int         rx_cycle;
    int         rx_hold_left;
    int         rx_seg_left;
    rx_style_t  rx_style;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Builds the exact character stream one request must produce.
    function automatic void format_expected(input i2a_pkg::fmt_t f);
        logic [63:0] v;
        logic [63:0] radix;
        logic [3:0]  digs[i2a_pkg::MAX_DIGITS];
        logic [7:0]  text[$];
        logic [7:0]  pref[$];
        int          ndig;
        int          width;
        int          prec;
        int          min_digits;
        int          zfill;
        int          core;
        int          pad;
        int          n;
        int          i;
        bit          zero_mode;

        v = f.value;
        case (f.base_select)
            i2a_pkg::BASE_OCT: radix = 64'd8;
            i2a_pkg::BASE_HEX: radix = 64'd16;
            default:           radix = 64'd10;
        endcase
        width = (f.field_width > i2a_pkg::MAX_WIDTH) ? i2a_pkg::MAX_WIDTH
                                                     : int'(f.field_width);
        prec = (f.precision > i2a_pkg::MAX_PREC) ? i2a_pkg::MAX_PREC : int'(f.precision);
        min_digits = f.precision_given ? prec : 1;

        ndig = 0;
        while (v != 0 && ndig < i2a_pkg::MAX_DIGITS)
        begin
            digs[ndig] = 4'(v % radix);
            v = v / radix;
            ndig++;
        end

        zfill = (min_digits > ndig) ? min_digits - ndig : 0;
        // octal '#' adds a 0 only if the digit text doesn't start with one already
        if (f.alt_form && radix == 64'd8 && zfill == 0)
        begin
            pref.push_back(i2a_pkg::CH_ZERO);
        end
        else if (f.alt_form && radix == 64'd16 && ndig != 0)
        begin
            pref.push_back(i2a_pkg::CH_ZERO);
            pref.push_back(f.uppercase ? i2a_pkg::CH_X_UP : i2a_pkg::CH_X_LO);
        end

        core = ((f.sign_code != i2a_pkg::SIGN_NONE) ? 1 : 0) + pref.size() + zfill + ndig;
        pad = (width > core) ? width - core : 0;
        zero_mode = f.zero_pad && !f.left_adjust && !f.precision_given;

        if (!f.left_adjust && !zero_mode)
        begin
            repeat (pad) text.push_back(i2a_pkg::CH_SPACE);
        end
        case (f.sign_code)
            i2a_pkg::SIGN_MINUS: text.push_back(i2a_pkg::CH_MINUS);
            i2a_pkg::SIGN_PLUS:  text.push_back(i2a_pkg::CH_PLUS);
            i2a_pkg::SIGN_SPACE: text.push_back(i2a_pkg::CH_SPACE);
            default: ;
        endcase
        foreach (pref[k])
        begin
            text.push_back(pref[k]);
        end
        if (zero_mode)
        begin
            repeat (pad) text.push_back(i2a_pkg::CH_ZERO);
        end
        repeat (zfill) text.push_back(i2a_pkg::CH_ZERO);
        for (i = ndig - 1; i >= 0; i--)
        begin
            if (digs[i] < 4'd10)
                text.push_back(i2a_pkg::CH_ZERO + {4'b0, digs[i]});
            else
                text.push_back((f.uppercase ? i2a_pkg::CH_A_UP : i2a_pkg::CH_A_LO)
                               + {4'b0, digs[i]} - 8'd10);
        end
        if (f.left_adjust)
        begin
            repeat (pad) text.push_back(i2a_pkg::CH_SPACE);
        end
        if (text.size() == 0)
        begin
            text.push_back(i2a_pkg::CH_ZERO);
        end

        n = (text.size() > i2a_pkg::MAX_WIDTH) ? i2a_pkg::MAX_WIDTH : text.size();
        for (i = 0; i < n; i++)
        begin
            expected_chars.push_back('{text[i], (i == n - 1)});
        end
    endfunction

    function automatic i2a_pkg::fmt_t fmt_of(input logic [63:0] value, input logic [1:0] bsel,
                                             input logic up, input logic alt, input logic left,
                                             input logic zpad, input logic [6:0] width,
                                             input logic pgiven, input logic [5:0] prec,
                                             input logic [1:0] sign);
        i2a_pkg::fmt_t f;
        f.value           = value;
        f.base_select     = bsel;
        f.uppercase       = up;
        f.alt_form        = alt;
        f.left_adjust     = left;
        f.zero_pad        = zpad;
        f.field_width     = width;
        f.precision_given = pgiven;
        f.precision       = prec;
        f.sign_code       = sign;
        return f;
    endfunction

    task automatic add_req(input i2a_pkg::fmt_t f, input bit drain);
        pending_reqs.push_back('{f, drain});
    endtask

    // Request acceptance: predict at the edge where the request is taken.
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
        begin
            format_expected(pending_reqs[0].fmt);
            in_fire <= 1'b1;
        end
        else
        begin
            in_fire <= 1'b0;
        end
    end

    // Request driver: bursts and gaps, valid held until accepted.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_fire)
            begin
                void'(pending_reqs.pop_front());
                burst_left--;
            end
            if (!(req.valid && !in_fire))
            begin
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 24);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    req.valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                begin
                    req.valid <= 1'b0;
                end
                else if (pending_reqs[0].drain_first && expected_chars.size() != 0)
                begin
                    req.valid <= 1'b0;
                end
                else
                begin
                    req.value           <= pending_reqs[0].fmt.value;
                    req.base_select     <= pending_reqs[0].fmt.base_select;
                    req.uppercase       <= pending_reqs[0].fmt.uppercase;
                    req.alt_form        <= pending_reqs[0].fmt.alt_form;
                    req.left_adjust     <= pending_reqs[0].fmt.left_adjust;
                    req.zero_pad        <= pending_reqs[0].fmt.zero_pad;
                    req.field_width     <= pending_reqs[0].fmt.field_width;
                    req.precision_given <= pending_reqs[0].fmt.precision_given;
                    req.precision       <= pending_reqs[0].fmt.precision;
                    req.sign_code       <= pending_reqs[0].fmt.sign_code;
                    req.valid           <= 1'b1;
                end
            end
        end
    end

    // Character receiver: segments of differing stall styles, plus two long hold-offs.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            rx_cycle++;
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                txt.ready <= 1'b0;
            end
            else if (rx_cycle == 4000 || rx_cycle == 25000)
            begin
                rx_hold_left = 500;
                txt.ready <= 1'b0;
            end
            else
            begin
                if (rx_seg_left == 0)
                begin
                    rx_seg_left = $urandom_range(10, 150);
                    rx_style = rx_style_t'($urandom_range(0, 3));
                end
                rx_seg_left--;
                case (rx_style)
                    RX_FREE:     txt.ready <= 1'b1;
                    RX_COIN:     txt.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE:   txt.ready <= ($urandom_range(0, 3) == 0);
                    RX_PERIODIC: txt.ready <= (rx_cycle % 3 != 0);
                    default:     txt.ready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && txt.valid && txt.ready)
        begin
            if (expected_chars.size() == 0)
            begin
                $error("txt: character %h with nothing expected", txt.out_char);
                mismatch_count++;
            end
            else
            begin
                want = expected_chars.pop_front();
                if (txt.out_char !== want.ch)
                begin
                    $error("out_char: expected %h, got %h", want.ch, txt.out_char);
                    mismatch_count++;
                end
                if (txt.last_char !== want.last)
                begin
                    $error("last_char: expected %b, got %b", want.last, txt.last_char);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        logic [63:0] v;
        logic [6:0]  w;
        logic [5:0]  p;
        logic [1:0]  b;
        int          i;

        clk = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.value = '0;
        req.base_select = i2a_pkg::BASE_DEC;
        req.uppercase = 1'b0;
        req.alt_form = 1'b0;
        req.left_adjust = 1'b0;
        req.zero_pad = 1'b0;
        req.field_width = '0;
        req.precision_given = 1'b0;
        req.precision = '0;
        req.sign_code = i2a_pkg::SIGN_NONE;
        txt.ready = 1'b0;
        in_fire = 1'b0;
        mismatch_count = 0;
        cycle_count = 0;
        burst_left = 0;
        gap_left = 0;
        rx_cycle = 0;
        rx_hold_left = 0;
        rx_seg_left = 0;
        rx_style = RX_FREE;

        // directed corners
        add_req(fmt_of(64'd0, i2a_pkg::BASE_DEC, 0, 0, 0, 0, 0, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd0, i2a_pkg::BASE_DEC, 0, 0, 0, 0, 0, 1, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd0, i2a_pkg::BASE_HEX, 0, 1, 0, 0, 5, 1, 0,
                       i2a_pkg::SIGN_PLUS), 0);
        add_req(fmt_of('1, i2a_pkg::BASE_OCT, 0, 1, 0, 0, 0, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of('1, i2a_pkg::BASE_DEC, 0, 0, 0, 0, 0, 0, 0,
                       i2a_pkg::SIGN_MINUS), 0);
        add_req(fmt_of('1, i2a_pkg::BASE_HEX, 1, 1, 0, 0, 0, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'hDEADBEEFCAFEF00D, i2a_pkg::BASE_HEX, 0, 1, 0, 1, 24, 0, 0,
                       i2a_pkg::SIGN_PLUS), 0);
        add_req(fmt_of(64'h0123456789ABCDEF, i2a_pkg::BASE_HEX, 1, 0, 0, 0, 0, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd12345, i2a_pkg::BASE_RSVD, 0, 0, 0, 0, 8, 0, 0,
                       i2a_pkg::SIGN_SPACE), 0);
        add_req(fmt_of(64'd0, i2a_pkg::BASE_OCT, 0, 1, 0, 0, 0, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd0, i2a_pkg::BASE_OCT, 0, 1, 0, 0, 0, 1, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd8, i2a_pkg::BASE_OCT, 0, 1, 0, 0, 0, 1, 5,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd0, i2a_pkg::BASE_HEX, 0, 1, 0, 0, 4, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd42, i2a_pkg::BASE_DEC, 0, 0, 0, 1, 10, 1, 4,
                       i2a_pkg::SIGN_PLUS), 0);
        add_req(fmt_of(64'd42, i2a_pkg::BASE_DEC, 0, 0, 1, 1, 10, 0, 0,
                       i2a_pkg::SIGN_MINUS), 0);
        add_req(fmt_of(64'd7, i2a_pkg::BASE_HEX, 0, 1, 0, 0, 127, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd1, i2a_pkg::BASE_HEX, 0, 1, 0, 0, 0, 1, 63,
                       i2a_pkg::SIGN_PLUS), 0);
        add_req(fmt_of(64'd1, i2a_pkg::BASE_OCT, 0, 1, 1, 0, 127, 1, 63,
                       i2a_pkg::SIGN_SPACE), 0);
        add_req(fmt_of(64'h8000000000000000, i2a_pkg::BASE_DEC, 0, 0, 0, 1, 64, 0, 0,
                       i2a_pkg::SIGN_SPACE), 0);
        add_req(fmt_of(64'd255, i2a_pkg::BASE_HEX, 1, 0, 1, 0, 3, 1, 2,
                       i2a_pkg::SIGN_NONE), 0);
        add_req(fmt_of(64'd9, i2a_pkg::BASE_DEC, 0, 0, 0, 1, 1, 0, 0,
                       i2a_pkg::SIGN_NONE), 0);

        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            case ($urandom_range(0, 5))
                0: v = 64'd0;
                1: v = 64'($urandom_range(1, 40));
                2: v = {$urandom, $urandom} >> $urandom_range(0, 63);
                3: v = {64{1'b1}} >> $urandom_range(0, 3);
                4: v = 64'd1 << $urandom_range(0, 63);
                default: v = {$urandom, $urandom};
            endcase
            case ($urandom_range(0, 9))
                0:       w = 7'($urandom_range(41, 127));
                1, 2, 3: w = 7'($urandom_range(13, 40));
                default: w = 7'($urandom_range(0, 12));
            endcase
            p = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(26, 63))
                                            : 6'($urandom_range(0, 25));
            b = ($urandom_range(0, 9) == 0) ? i2a_pkg::BASE_RSVD : 2'($urandom_range(0, 2));
            add_req(fmt_of(v, b, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), w,
                           1'($urandom_range(0, 1)), p, 2'($urandom_range(0, 3))),
                    (i % 70 == 0));
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_reqs.size() != 0 || expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && expected_chars.size() == 0)
        begin
            $display("tb: done, clean");
        end
        else
        begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
